### rtl/pcsm_pkg.sv
// ----------------------------------------------------------------------------
// pcsm_pkg: shared types and constants of the speaker tone mixer
// Item, stage and register structs, fixed-point constants for the service
// interval and half-period dividers, and the helpers that split a rate.
// ----------------------------------------------------------------------------
package pcsm_pkg;

    // Timing constants
    localparam int unsigned BASE_TIMER = 1193181;
    localparam int unsigned TONE_DIV   = 2 * BASE_TIMER;   // 2386362, 22 bits
    localparam int unsigned SVC_RATE   = 140;
    localparam int unsigned CODE_SCALE = 60;
    localparam int unsigned WAVE_AMP   = 'h2000;
    localparam int SAT_LOW  = -32768;
    localparam int SAT_HIGH = 32767;

    // x / 140 = (x * SVC_RECIP) >> SVC_SHIFT, low by at most one
    localparam int unsigned SVC_RECIP = 239674;
    localparam int unsigned SVC_SHIFT = 25;

    // u / TONE_DIV = (u * TONE_RECIP) >> TONE_SHIFT, low by at most one (u < 2^30)
    localparam int unsigned TONE_RECIP = 449;
    localparam int unsigned TONE_SHIFT = 30;

    // 60 * rate / TONE_DIV never exceeds this for an 18-bit rate
    localparam int unsigned PER_QUOT_MAX = 6;

    // Register map
    typedef enum logic {
        REG_SAMPLE_RATE  = 1'b0,
        REG_SPEAKER_MODE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [10:0] quot;   // rate / 140
        logic [7:0]  rem;    // rate % 140
    } svc_split_t;

    typedef struct packed {
        logic [2:0]  quot;   // 60*rate / TONE_DIV
        logic [21:0] rem;    // 60*rate % TONE_DIV
    } per_split_t;

    typedef struct packed {
        logic [17:0] sample_rate;
        logic        speaker_mode;
        svc_split_t  svc;
        per_split_t  per;
    } cfg_t;

    typedef struct packed {
        logic        restart;
        logic [15:0] left_in;
        logic [15:0] right_in;
        logic        code_valid;
        logic [7:0]  tone_code;
        logic        code_last;
    } item_t;

    // Item plus the two partial products of the half period
    typedef struct packed {
        item_t       item;
        logic [29:0] frac_prod;   // tone_code * per.rem
        logic [10:0] whole_prod;  // tone_code * per.quot
    } stage_t;

    typedef struct packed {
        logic [15:0] left_out;
        logic [15:0] right_out;
        logic        code_taken;
        logic        sound_ended;
    } result_t;

    typedef struct packed {
        logic [11:0] countdown;
        logic [7:0]  tick_rem;
        logic [15:0] phase;
        logic [15:0] half_period;
        logic        level_negative;
        logic        tone_on;
        logic [7:0]  last_code;
        logic        force_update;
    } mix_state_t;

    localparam mix_state_t MIX_CLEAR = '{
        countdown:      12'd0,
        tick_rem:       8'd0,
        phase:          16'd0,
        half_period:    16'd1,
        level_negative: 1'b0,
        tone_on:        1'b0,
        last_code:      8'd0,
        force_update:   1'b1
    };

    function automatic svc_split_t svc_split(input logic [17:0] rate);
        logic [35:0] prod;
        logic [10:0] q0;
        logic [17:0] r0;
        svc_split_t  res;
        prod = 36'(rate) * 36'(SVC_RECIP);
        q0   = prod[SVC_SHIFT +: 11];
        r0   = rate - 18'(q0) * 18'(SVC_RATE);
        if (r0 >= 18'(SVC_RATE))
        begin
            res.quot = q0 + 11'd1;
            res.rem  = 8'(r0 - 18'(SVC_RATE));
        end
        else
        begin
            res.quot = q0;
            res.rem  = 8'(r0);
        end
        return res;
    endfunction

    function automatic per_split_t per_split(input logic [17:0] rate);
        logic [23:0] scaled;
        logic [2:0]  q;
        per_split_t  res;
        scaled = 24'(rate) * 24'(CODE_SCALE);
        q = 3'd0;
        for (int k = 1; k <= int'(PER_QUOT_MAX); k++)
        begin
            if (scaled >= 24'(k * TONE_DIV))
                q = 3'(k);
        end
        res.quot = q;
        res.rem  = 22'(scaled - 24'(q) * 24'(TONE_DIV));
        return res;
    endfunction

    localparam cfg_t CFG_RESET = '{
        sample_rate:  18'd44100,
        speaker_mode: 1'b0,
        svc:          svc_split(18'd44100),
        per:          per_split(18'd44100)
    };

endpackage

### rtl/pcsm_regs.sv
// ----------------------------------------------------------------------------
// pcsm_regs: configuration registers
// APB-style write/read of sample_rate and speaker_mode; the rate is split
// into service and half-period quotients at write time.
// ----------------------------------------------------------------------------
module pcsm_regs
    import pcsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_sel;
    logic     wr_en;

    assign reg_sel = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_SAMPLE_RATE:
                begin
                    cfg_next.sample_rate = pwdata[17:0];
                    cfg_next.svc         = svc_split(pwdata[17:0]);
                    cfg_next.per         = per_split(pwdata[17:0]);
                end
                REG_SPEAKER_MODE:
                begin
                    cfg_next.speaker_mode = pwdata[0];
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SAMPLE_RATE:  prdata = 32'(cfg_reg.sample_rate);
            REG_SPEAKER_MODE: prdata = 32'(cfg_reg.speaker_mode);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

endmodule

### rtl/pcsm_tone.sv
// ----------------------------------------------------------------------------
// pcsm_tone: mixer state and square-wave mixing
// Finishes the half-period division, services tone codes, steps the square
// wave and adds it to both channels with saturation. State moves on advance.
// ----------------------------------------------------------------------------
module pcsm_tone
    import pcsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       speaker_mode,
    input  svc_split_t svc,
    input  stage_t     stage,
    input  logic [8:0] frac_est,
    output result_t    result
);

    mix_state_t  state_reg;
    mix_state_t  state_next;
    mix_state_t  cur;
    logic        bypass;
    logic [29:0] frac_left;
    logic        frac_fix;
    logic [11:0] per_raw;
    logic [15:0] per_new;
    logic [8:0]  tick_sum;
    logic [7:0]  tick_new;
    logic [11:0] interval;
    logic [15:0] phase_inc;
    logic signed [16:0] level;
    logic        taken;
    logic        ended;

    function automatic logic [15:0] sat_add(input logic [15:0] s,
                                            input logic signed [16:0] add);
        logic signed [16:0] sum;
        sum = $signed({s[15], s}) + add;
        if (sum < 17'(SAT_LOW))
            return 16'(SAT_LOW);
        else if (sum > 17'(SAT_HIGH))
            return 16'(SAT_HIGH);
        else
            return sum[15:0];
    endfunction

    // half period = code*quot + floor(code*rem / TONE_DIV), at least 1
    assign frac_left = stage.frac_prod - 30'(frac_est) * 30'(TONE_DIV);
    assign frac_fix  = (frac_left >= 30'(TONE_DIV));
    assign per_raw   = 12'(stage.whole_prod) + 12'(frac_est) + 12'(frac_fix);
    assign per_new   = (per_raw == 12'd0) ? 16'd1 : 16'(per_raw);

    assign cur    = stage.item.restart ? MIX_CLEAR : state_reg;
    assign bypass = !speaker_mode && !stage.item.code_valid && !cur.tone_on;

    // service interval with remainder carry
    assign tick_sum = {1'b0, cur.tick_rem} + {1'b0, svc.rem};
    always_comb
    begin
        if (tick_sum >= 9'(SVC_RATE))
        begin
            tick_new = 8'(tick_sum - 9'(SVC_RATE));
            interval = 12'(svc.quot) + 12'd1;
        end
        else
        begin
            tick_new = tick_sum[7:0];
            interval = (svc.quot == 11'd0) ? 12'd1 : 12'(svc.quot);
        end
    end

    always_comb
    begin
        state_next = cur;
        taken      = 1'b0;
        ended      = 1'b0;
        level      = '0;
        phase_inc  = '0;
        if (!bypass)
        begin
            if (cur.countdown == 12'd0)
            begin
                if (stage.item.code_valid)
                begin
                    taken = 1'b1;
                    if (cur.force_update || stage.item.tone_code != cur.last_code)
                    begin
                        state_next.force_update = 1'b0;
                        state_next.last_code    = stage.item.tone_code;
                        if (stage.item.tone_code != 8'd0)
                        begin
                            state_next.half_period = per_new;
                            state_next.tone_on     = 1'b1;
                        end
                        else
                        begin
                            state_next.tone_on        = 1'b0;
                            state_next.phase          = '0;
                            state_next.level_negative = 1'b0;
                        end
                    end
                    if (stage.item.code_last)
                    begin
                        state_next.tone_on        = 1'b0;
                        state_next.phase          = '0;
                        state_next.level_negative = 1'b0;
                        ended                     = 1'b1;
                    end
                end
                else
                begin
                    state_next.tone_on        = 1'b0;
                    state_next.phase          = '0;
                    state_next.level_negative = 1'b0;
                end
                state_next.tick_rem  = tick_new;
                state_next.countdown = interval;
            end

            if (state_next.tone_on)
            begin
                level     = state_next.level_negative ? -17'(WAVE_AMP) : 17'(WAVE_AMP);
                phase_inc = state_next.phase + 16'd1;
                if (phase_inc >= state_next.half_period)
                begin
                    state_next.phase          = '0;
                    state_next.level_negative = !state_next.level_negative;
                end
                else
                begin
                    state_next.phase = phase_inc;
                end
            end

            state_next.countdown = state_next.countdown - 12'd1;
        end
    end

    assign result.left_out    = sat_add(stage.item.left_in, level);
    assign result.right_out   = sat_add(stage.item.right_in, level);
    assign result.code_taken  = taken;
    assign result.sound_ended = ended;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= MIX_CLEAR;
        else if (advance)
            state_reg <= state_next;
    end

    // carried remainder stays below one service period
    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.tick_rem < 8'(SVC_RATE))
        else $error("tick remainder out of range");

    a_half_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.half_period != 16'd0)
        else $error("half period is zero");

    a_end_silent: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.sound_ended |=> !state_reg.tone_on)
        else $error("tone still on after last code");

    a_taken_clears_force: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.code_taken |=> !state_reg.force_update)
        else $error("forced update left pending after a code transfer");

endmodule

### rtl/pc_speaker_square_wave_mixer_top.sv
// ----------------------------------------------------------------------------
// pc_speaker_square_wave_mixer_top: square-wave tone mixer, top level
// Mixes a +/-0x2000 speaker square wave into a stereo 16-bit frame stream.
// ----------------------------------------------------------------------------
// Usage: one stereo frame per transfer, one per clock while out_ready is high. A
// frame passes three registers: an input stage holding the tone-code
// partial products, a stage holding the half-period quotient estimate from
// a reciprocal multiply, and the output register, loaded by the mixer whose
// state (service countdown, phase, level, last code) updates once per frame.
// A taken frame moves through the input and second stages into the output
// register, where out_valid rises, and leaves with out_ready high. A held output
// stalls a stage only once every stage ahead of it is full; in_ready drops
// when all three registers hold frames and follows out_ready combinationally.
// Tone codes ride with the frames and are consumed at about 140 Hz of the
// configured sample_rate; code_taken marks a consumed code and sound_ended
// the final one. restart clears the mixer state before its own frame. While
// speaker_mode is 0, no code is offered and no tone is playing, frames pass
// through untouched. sample_rate (0x0) and speaker_mode (0x4) should be
// written only while no frame is in flight; the rate is split into its
// service and half-period quotients in the write cycle itself.
// ----------------------------------------------------------------------------
module pc_speaker_square_wave_mixer_top
    import pcsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // frame input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    input  logic [15:0] left_in,
    input  logic [15:0] right_in,
    input  logic        code_valid,
    input  logic [7:0]  tone_code,
    input  logic        code_last,

    // frame output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] left_out,
    output logic [15:0] right_out,
    output logic        code_taken,
    output logic        sound_ended
);

    cfg_t        cfg;
    item_t       in_item;
    stage_t      in_stage;

    stage_t      s1_reg;
    logic        s1_valid_reg;
    stage_t      s2_reg;
    logic [8:0]  s2_est_reg;
    logic        s2_valid_reg;
    result_t     out_reg;
    logic        out_valid_reg;

    logic [38:0] est_prod;
    logic        out_free;
    logic        s2_free;
    logic        s1_free;
    logic        s2_adv;
    logic        s1_adv;
    logic        in_xfer;
    result_t     mix_result;

    pcsm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline handshake: a stage frees when empty or when its successor can take its item
    assign out_free = !out_valid_reg || out_ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_ready = s1_free;
    assign in_xfer  = in_valid && s1_free;

    // Input stage: half-period partial products from the tone code
    assign in_item = '{
        restart:    restart,
        left_in:    left_in,
        right_in:   right_in,
        code_valid: code_valid,
        tone_code:  tone_code,
        code_last:  code_last
    };
    assign in_stage.item       = in_item;
    assign in_stage.frac_prod  = 30'(tone_code) * 30'(cfg.per.rem);
    assign in_stage.whole_prod = 11'(tone_code) * 11'(cfg.per.quot);

    // Second stage: quotient estimate of frac_prod / TONE_DIV
    assign est_prod = 39'(s1_reg.frac_prod) * 39'(TONE_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= in_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_reg <= in_stage;
        if (s1_adv)
        begin
            s2_reg     <= s1_reg;
            s2_est_reg <= 9'(est_prod >> TONE_SHIFT);
        end
        if (s2_adv)
            out_reg <= mix_result;
    end

    // Mixer stage: state moves only when the frame moves to the output
    pcsm_tone u_tone (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (s2_adv),
        .speaker_mode (cfg.speaker_mode),
        .svc          (cfg.svc),
        .stage        (s2_reg),
        .frac_est     (s2_est_reg),
        .result       (mix_result)
    );

    assign out_valid   = out_valid_reg;
    assign left_out    = out_reg.left_out;
    assign right_out   = out_reg.right_out;
    assign code_taken  = out_reg.code_taken;
    assign sound_ended = out_reg.sound_ended;

endmodule
